### hdl/pbpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the paged block pool allocator.
// No dependencies; used by the front queue, the back executor and the top level.
package pbpa_pkg;

  localparam int HANDLE_W    = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 96;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 25;
  localparam int SYS_W       = 26;
  localparam int BB_W        = 13;
  localparam int BPPR_W      = 9;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int LINK_DEPTH  = 4096;
  localparam int LEN_W       = 13;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_PAGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_TAG        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_OVERHEAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_OVERHEAD   = 3'd4;

  localparam logic [BB_W-1:0]   RST_BLOCK_BYTES     = 13'd64;
  localparam logic [BPPR_W-1:0] RST_BLOCKS_PER_PAGE = 9'd256;
  localparam logic [BYTE_W-1:0] RST_POOL_TAG        = 8'd0;
  localparam logic [BYTE_W-1:0] RST_PAGE_OVERHEAD   = 8'd32;
  localparam logic [BYTE_W-1:0] RST_POOL_OVERHEAD   = 8'd80;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } status_t;

  typedef struct packed {
    logic [BB_W-1:0]   block_bytes;
    logic [BPPR_W-1:0] blocks_per_page;
    logic [BYTE_W-1:0] pool_tag;
    logic [BYTE_W-1:0] page_overhead_bytes;
    logic [BYTE_W-1:0] pool_overhead_bytes;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [BYTE_W-1:0]   granted_tag;
    logic [CNT_W-1:0]    allocated_bytes;
    logic [CNT_W-1:0]    free_bytes;
    logic [SYS_W-1:0]    used_bytes;
  } res_t;

endpackage

### hdl/pbpa_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the command and holds them in a
// two-entry queue for the executor. Depends on pbpa_pkg.
module pbpa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pbpa_pkg::HANDLE_W-1:0] in_handle,
  input  logic                          in_cmd,
  output logic                          q_valid,
  output pbpa_pkg::req_t                q_req,
  input  logic                          q_pop
);

  pbpa_pkg::req_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  pbpa_pkg::req_t dec;

  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_req     = entry_r[rd_ptr_r];
  assign push      = in_tvalid & in_tready;

  always_comb begin
    dec.handle = in_handle;
    case (in_cmd)
      1'b1:    dec.op = pbpa_pkg::OP_FREE;
      default: dec.op = pbpa_pkg::OP_ALLOC;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### hdl/pbpa_back.sv
`timescale 1ns / 1ps
// Back end: executes one request at a time against the freed list, the page
// state and the byte counters; owns the link memory and the result register.
// Depends on pbpa_pkg.
module pbpa_back #(
  parameter int MAX_PAGES           = 16,
  parameter int MAX_BLOCKS_PER_PAGE = 256,
  parameter int BLOCK_ALIGN         = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pbpa_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  pbpa_pkg::req_t q_req,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output pbpa_pkg::res_t out_res
);

  localparam int HW      = pbpa_pkg::HANDLE_W;
  localparam int BB_W    = pbpa_pkg::BB_W;
  localparam int CNT_W   = pbpa_pkg::CNT_W;
  localparam int SYS_W   = pbpa_pkg::SYS_W;
  localparam int LEN_W   = pbpa_pkg::LEN_W;
  localparam int PG_W    = $clog2(MAX_PAGES + 1);
  localparam int BPP_W   = $clog2(MAX_BLOCKS_PER_PAGE + 1);
  localparam int BASE_W  = PG_W + BPP_W;
  localparam int SUM_W   = BASE_W + 1;
  localparam int ALIGN_W = $clog2((1 << BB_W) + 2 * BLOCK_ALIGN);
  localparam int PB_W    = ALIGN_W + BPP_W;
  // floor(x / BLOCK_ALIGN) by reciprocal; the estimate is low by at most one
  localparam int DIV_SHIFT = BB_W;
  localparam int RECIP_W   = BB_W + 1;
  localparam int PROD_W    = BB_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_SHIFT) / BLOCK_ALIGN);
  localparam logic [BB_W-1:0]    ALIGN_BB = BB_W'(BLOCK_ALIGN);
  localparam logic [ALIGN_W-1:0] ALIGN_AW = ALIGN_W'(BLOCK_ALIGN);
  localparam logic [LEN_W-1:0]   LIST_FULL = LEN_W'(pbpa_pkg::LINK_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CALC = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_ALN  = 7'b0001000,
    S_RND  = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_OPEN = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  pbpa_pkg::op_t     op_r, op_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic [HW-1:0]     head_r, head_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PG_W-1:0]   pages_r, pages_nxt;
  logic [BPP_W-1:0]  fs_r, fs_nxt;
  logic [CNT_W-1:0]  acnt_r, acnt_nxt;
  logic [CNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [SYS_W-1:0]  scnt_r, scnt_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [BB_W-1:0]   q0_r, q0_nxt;
  logic [BB_W-1:0]   r0_r, r0_nxt;
  logic [ALIGN_W-1:0] aligned_r, aligned_nxt;
  logic [PB_W-1:0]   pb_r, pb_nxt;
  logic              out_valid_r, out_valid_nxt;
  pbpa_pkg::res_t    res_r, res_nxt;

  logic [HW-1:0]     link_mem [pbpa_pkg::LINK_DEPTH];
  logic [HW-1:0]     rdata_r;
  logic              mem_we, mem_re;

  logic [BPP_W-1:0]  bpp_eff;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // effective blocks per page, clamped to 1..MAX_BLOCKS_PER_PAGE
  always_comb begin
    if (cfg.blocks_per_page == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (32'(cfg.blocks_per_page) > 32'(MAX_BLOCKS_PER_PAGE)) begin
      bpp_eff = BPP_W'(MAX_BLOCKS_PER_PAGE);
    end else begin
      bpp_eff = BPP_W'(cfg.blocks_per_page);
    end
  end

  always_comb begin
    logic                 fin;
    pbpa_pkg::status_t    st;
    logic [HW-1:0]        gh;
    logic [7:0]           gt;
    logic [PG_W-1:0]      pm1;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     sum;
    logic [BPP_W-1:0]     fs_cap;
    logic [BB_W-1:0]      diff;
    logic [ALIGN_W-1:0]   rdown;
    logic [ALIGN_W-1:0]   rup;
    logic                 ok;

    fin  = 1'b0;
    st   = pbpa_pkg::ST_OK;
    gh   = '0;
    gt   = '0;
    pm1  = pages_r - PG_W'(1);
    prod = PROD_W'(cfg.block_bytes) * PROD_W'(RECIP);
    sum  = '0;
    fs_cap = '0;
    diff = '0;
    rdown = '0;
    rup  = '0;
    ok   = 1'b0;

    state_nxt   = state_r;
    op_nxt      = op_r;
    h_nxt       = h_r;
    head_nxt    = head_r;
    len_nxt     = len_r;
    pages_nxt   = pages_r;
    fs_nxt      = fs_r;
    acnt_nxt    = acnt_r;
    fcnt_nxt    = fcnt_r;
    scnt_nxt    = scnt_r;
    base_nxt    = base_r;
    q0_nxt      = q0_r;
    r0_nxt      = r0_r;
    aligned_nxt = aligned_r;
    pb_nxt      = pb_r;
    res_nxt     = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    q_pop  = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;

    case (state_r)
      S_IDLE: begin
        // start only when the result register will be free at the finish
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop     = 1'b1;
          op_nxt    = q_req.op;
          h_nxt     = q_req.handle;
          mem_re    = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        base_nxt = BASE_W'(pm1) * BASE_W'(bpp_eff);
        q0_nxt   = prod[DIV_SHIFT +: BB_W];
        if (op_r == pbpa_pkg::OP_ALLOC && len_r != '0) begin
          // pop the freed list: link of the head came back this cycle
          fin      = 1'b1;
          gh       = head_r;
          gt       = cfg.pool_tag;
          head_nxt = rdata_r;
          len_nxt  = len_r - LEN_W'(1);
          acnt_nxt = acnt_r + CNT_W'(cfg.block_bytes);
          fcnt_nxt = fcnt_r - CNT_W'(cfg.block_bytes);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == pbpa_pkg::OP_ALLOC) begin
          if (pages_r == '0 || fs_r >= bpp_eff) begin
            if (32'(pages_r) < 32'(MAX_PAGES)) begin
              state_nxt = S_ALN;
            end else begin
              fin = 1'b1;
              st  = pbpa_pkg::ST_EXHAUSTED;
              state_nxt = S_IDLE;
            end
          end else begin
            sum      = SUM_W'(base_r) + SUM_W'(fs_r);
            fin      = 1'b1;
            gh       = HW'(sum);
            gt       = cfg.pool_tag;
            fs_nxt   = fs_r + BPP_W'(1);
            acnt_nxt = acnt_r + CNT_W'(cfg.block_bytes);
            fcnt_nxt = fcnt_r - CNT_W'(cfg.block_bytes);
            state_nxt = S_IDLE;
          end
        end else begin
          fs_cap = (fs_r < bpp_eff) ? fs_r : bpp_eff;
          if (pages_r != '0) begin
            sum = SUM_W'(base_r) + SUM_W'(fs_cap);
          end
          ok  = (32'(h_r) < 32'(sum)) && (len_r != LIST_FULL);
          fin = 1'b1;
          if (ok) begin
            mem_we   = 1'b1;
            head_nxt = h_r;
            len_nxt  = len_r + LEN_W'(1);
            acnt_nxt = acnt_r - CNT_W'(cfg.block_bytes);
            fcnt_nxt = fcnt_r + CNT_W'(cfg.block_bytes);
          end else begin
            st = pbpa_pkg::ST_BAD_HANDLE;
          end
          state_nxt = S_IDLE;
        end
      end
      S_ALN: begin
        r0_nxt    = BB_W'(q0_r * ALIGN_BB);
        state_nxt = S_RND;
      end
      S_RND: begin
        // fix the low estimate, round up, add one alignment unit
        diff  = cfg.block_bytes - r0_r;
        rdown = ALIGN_W'(r0_r) + ((diff >= ALIGN_BB) ? ALIGN_AW : '0);
        rup   = rdown + ((ALIGN_W'(cfg.block_bytes) != rdown) ? ALIGN_AW : '0);
        aligned_nxt = rup + ALIGN_AW;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        pb_nxt    = PB_W'(aligned_r) * PB_W'(bpp_eff);
        state_nxt = S_OPEN;
      end
      S_OPEN: begin
        scnt_nxt  = scnt_r + SYS_W'(cfg.page_overhead_bytes) + SYS_W'(pb_r);
        fcnt_nxt  = fcnt_r + CNT_W'(pb_r);
        pages_nxt = pages_r + PG_W'(1);
        fs_nxt    = '0;
        // recompute the page base with the new page count
        state_nxt = S_CALC;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt           = 1'b1;
      res_nxt.status          = st;
      res_nxt.granted_handle  = gh;
      res_nxt.granted_tag     = gt;
      res_nxt.allocated_bytes = acnt_nxt;
      res_nxt.free_bytes      = fcnt_nxt;
      res_nxt.used_bytes      = scnt_nxt + SYS_W'(cfg.pool_overhead_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pages_r     <= '0;
      fs_r        <= '0;
      acnt_r      <= '0;
      fcnt_r      <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pages_r     <= pages_nxt;
      fs_r        <= fs_nxt;
      acnt_r      <= acnt_nxt;
      fcnt_r      <= fcnt_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    h_r       <= h_nxt;
    head_r    <= head_nxt;
    base_r    <= base_nxt;
    q0_r      <= q0_nxt;
    r0_r      <= r0_nxt;
    aligned_r <= aligned_nxt;
    pb_r      <= pb_nxt;
    res_r     <= res_nxt;
  end

  // link memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[h_r] <= head_r;
    end
    if (mem_re) begin
      rdata_r <= link_mem[head_r];
    end
  end

endmodule

### hdl/paged_block_pool_allocator.sv
`timescale 1ns / 1ps
// Paged block pool allocator. An alloc served from the freed list finishes in
// the calc state; a fresh-slot alloc or a free in the exec state; an alloc that
// opens a page runs align, round, multiply and open, then calc and exec again.
// One request is executed at a time; the next is started only after it finishes.
// Synchronous active-low reset clears the counters, the page state and the freed
// list length; the link memory is not cleared. Uses pbpa_pkg, pbpa_front, pbpa_back.
module paged_block_pool_allocator #(
  parameter int MAX_PAGES           = 16,
  parameter int MAX_BLOCKS_PER_PAGE = 256,
  parameter int BLOCK_ALIGN         = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pbpa_pkg::IN_TDATA_W-1:0]   in_tdata,   // block_handle[11:0], zero pad
  input  logic                              in_tuser,   // cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // granted_handle[11:0], granted_tag[19:12], allocated_bytes[44:20],
  // free_bytes[69:45], used_bytes[95:70]
  output logic [pbpa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [pbpa_pkg::STATUS_W-1:0]     out_tuser,  // status
  input  logic                              cfg_we,
  input  logic [pbpa_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [pbpa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pbpa_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_valid;
  pbpa_pkg::req_t q_req;
  logic           q_pop;
  pbpa_pkg::res_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        pbpa_pkg::REG_BLOCK_BYTES:     cfg_nxt.block_bytes = cfg_wdata;
        pbpa_pkg::REG_BLOCKS_PER_PAGE: cfg_nxt.blocks_per_page = cfg_wdata[8:0];
        pbpa_pkg::REG_POOL_TAG:        cfg_nxt.pool_tag = cfg_wdata[7:0];
        pbpa_pkg::REG_PAGE_OVERHEAD:   cfg_nxt.page_overhead_bytes = cfg_wdata[7:0];
        pbpa_pkg::REG_POOL_OVERHEAD:   cfg_nxt.pool_overhead_bytes = cfg_wdata[7:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_bytes         <= pbpa_pkg::RST_BLOCK_BYTES;
      cfg_r.blocks_per_page     <= pbpa_pkg::RST_BLOCKS_PER_PAGE;
      cfg_r.pool_tag            <= pbpa_pkg::RST_POOL_TAG;
      cfg_r.page_overhead_bytes <= pbpa_pkg::RST_PAGE_OVERHEAD;
      cfg_r.pool_overhead_bytes <= pbpa_pkg::RST_POOL_OVERHEAD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pbpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_handle (in_tdata[pbpa_pkg::HANDLE_W-1:0]),
    .in_cmd    (in_tuser),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  pbpa_back #(
    .MAX_PAGES           (MAX_PAGES),
    .MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE),
    .BLOCK_ALIGN         (BLOCK_ALIGN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {res.used_bytes, res.free_bytes, res.allocated_bytes,
                      res.granted_tag, res.granted_handle};

endmodule
